// ===== hdl/obra_pkg.sv =====
`timescale 1ns / 1ps

package obra_pkg;

  // field and datapath widths
  localparam int COORD_W     = 16;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 33;
  localparam int DOT_W       = 34;
  localparam int WEIGHT_W    = 38;
  localparam int AVG_W       = 17;
  localparam int OUT_COUNT_W = 20;
  localparam int CFG_IDX_W   = 3;

  // restoring divider runs one quotient bit per cycle over the weight magnitude
  localparam int DIV_STEPS = WEIGHT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // average clamp limits, as magnitudes of the quotient
  localparam logic [WEIGHT_W-1:0] AVG_POS_MAX = WEIGHT_W'(65535);
  localparam logic [WEIGHT_W-1:0] AVG_NEG_MAG = WEIGHT_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_A_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_A_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_B_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_B_Y = 3'd5;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SQ4,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_TEST,
    ST_UPDATE,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } obra_state_t;

  // datapath operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_SQ0,
    DP_SQ1,
    DP_SQ2,
    DP_SQ3,
    DP_SQ4,
    DP_M0,
    DP_M1,
    DP_M2,
    DP_M3,
    DP_TEST,
    DP_UPDATE,
    DP_PREP,
    DP_DIV,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic acc_empty;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== hdl/obra_ctrl.sv =====
`timescale 1ns / 1ps

module obra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_we,
  output obra_pkg::dp_cmd_t    cmd,
  input  obra_pkg::dp_status_t status
);
  import obra_pkg::*;

  obra_state_t          state_r, state_nxt;
  logic                 dirty_r, dirty_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 take;

  // a word is taken only when idle with the side squares up to date
  assign take = (state_r == ST_IDLE) && !dirty_r && in_valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (dirty_r) begin
          state_nxt = ST_SQ0;
        end else if (in_valid) begin
          state_nxt = ST_M0;
        end
      end
      ST_SQ0:    state_nxt = ST_SQ1;
      ST_SQ1:    state_nxt = ST_SQ2;
      ST_SQ2:    state_nxt = ST_SQ3;
      ST_SQ3:    state_nxt = ST_SQ4;
      ST_SQ4:    state_nxt = ST_IDLE;
      ST_M0:     state_nxt = ST_M1;
      ST_M1:     state_nxt = ST_M2;
      ST_M2:     state_nxt = ST_M3;
      ST_M3:     state_nxt = ST_TEST;
      ST_TEST:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = status.last ? ST_PREP : ST_IDLE;
      ST_PREP:   state_nxt = status.acc_empty ? ST_OUT : ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // squares go stale on any register write; a write during the pass reruns it
  always_comb begin
    dirty_nxt = dirty_r;
    if (cfg_we) begin
      dirty_nxt = 1'b1;
    end else if (state_r == ST_SQ0) begin
      dirty_nxt = 1'b0;
    end
  end

  // divider step counter
  always_comb begin
    div_cnt_nxt = div_cnt_r;
    if (state_r == ST_PREP) begin
      div_cnt_nxt = DIV_CNT_W'(DIV_STEPS - 1);
    end else if (state_r == ST_DIV) begin
      div_cnt_nxt = div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dirty_r   <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      dirty_r   <= dirty_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // outputs
  always_comb begin
    in_stall = !((state_r == ST_IDLE) && !dirty_r);
    cmd.op   = DP_NOP;
    case (state_r)
      ST_IDLE:   cmd.op = take ? DP_LOAD : DP_NOP;
      ST_SQ0:    cmd.op = DP_SQ0;
      ST_SQ1:    cmd.op = DP_SQ1;
      ST_SQ2:    cmd.op = DP_SQ2;
      ST_SQ3:    cmd.op = DP_SQ3;
      ST_SQ4:    cmd.op = DP_SQ4;
      ST_M0:     cmd.op = DP_M0;
      ST_M1:     cmd.op = DP_M1;
      ST_M2:     cmd.op = DP_M2;
      ST_M3:     cmd.op = DP_M3;
      ST_TEST:   cmd.op = DP_TEST;
      ST_UPDATE: cmd.op = DP_UPDATE;
      ST_PREP:   cmd.op = DP_PREP;
      ST_DIV:    cmd.op = DP_DIV;
      ST_OUT:    cmd.op = status.out_busy ? DP_NOP : DP_OUT;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule

// ===== hdl/obra_dp.sv =====
`timescale 1ns / 1ps

module obra_dp #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  obra_pkg::dp_cmd_t                          cmd,
  output obra_pkg::dp_status_t                       status,
  input  logic                                      cfg_we,
  input  logic [obra_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [obra_pkg::COORD_W-1:0]              cfg_wdata,
  input  logic signed [obra_pkg::COORD_W-1:0]       in_point_x,
  input  logic signed [obra_pkg::COORD_W-1:0]       in_point_y,
  input  logic                                      in_last_point,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output logic [obra_pkg::OUT_COUNT_W-1:0]          out_inside_count,
  output logic signed [obra_pkg::WEIGHT_W-1:0]      out_weight_total,
  output logic signed [obra_pkg::AVG_W-1:0]         out_weight_average,
  output logic                                      out_set_empty
);
  import obra_pkg::*;

  // box registers
  logic signed [COORD_W-1:0] corner_x_r, corner_y_r;
  logic signed [COORD_W-1:0] side_a_x_r, side_a_y_r, side_b_x_r, side_b_y_r;

  // current point
  logic signed [DIFF_W-1:0] dx_r, dy_r, w_r;
  logic                     last_r;

  // shared multiplier and dot products
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DOT_W-1:0]   prod_ext;
  logic signed [DOT_W-1:0]   near_a_r, near_b_r, sq_a_r, sq_b_r;
  logic signed [DOT_W-1:0]   near_b_sum;
  logic                      in_a_r, inside_r;

  // running sums
  logic [COUNT_BITS-1:0]      count_acc_r;
  logic signed [WEIGHT_W-1:0] weight_acc_r;
  logic signed [WEIGHT_W:0]   weight_sum;
  logic signed [WEIGHT_W-1:0] weight_sat;

  // result hold and divider
  logic [COUNT_BITS-1:0]      cnt_hold_r;
  logic signed [WEIGHT_W-1:0] wt_hold_r;
  logic                       neg_r;
  logic [WEIGHT_W-1:0]        dvd_r;
  logic [COUNT_BITS:0]        rem_r;
  logic [COUNT_BITS:0]        rem_sh;
  logic [COUNT_BITS+1:0]      rem_diff;
  logic [WEIGHT_W-1:0]        weight_mag;
  logic [AVG_W-1:0]           avg_val;
  logic [COUNT_BITS+OUT_COUNT_W-1:0] count_wide;

  // output register
  logic                       out_valid_r;
  logic [OUT_COUNT_W-1:0]     out_count_r;
  logic signed [WEIGHT_W-1:0] out_total_r;
  logic signed [AVG_W-1:0]    out_avg_r;
  logic                       out_empty_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_x_r <= '0;
      corner_y_r <= '0;
      side_a_x_r <= '0;
      side_a_y_r <= '0;
      side_b_x_r <= '0;
      side_b_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORNER_X: corner_x_r <= cfg_wdata;
        REG_CORNER_Y: corner_y_r <= cfg_wdata;
        REG_SIDE_A_X: side_a_x_r <= cfg_wdata;
        REG_SIDE_A_Y: side_a_y_r <= cfg_wdata;
        REG_SIDE_B_X: side_b_x_r <= cfg_wdata;
        REG_SIDE_B_Y: side_b_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // point capture: offsets from the corner and the weight
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      dx_r   <= $signed({in_point_x[COORD_W-1], in_point_x})
              - $signed({corner_x_r[COORD_W-1], corner_x_r});
      dy_r   <= $signed({in_point_y[COORD_W-1], in_point_y})
              - $signed({corner_y_r[COORD_W-1], corner_y_r});
      w_r    <= $signed({in_point_x[COORD_W-1], in_point_x})
              + $signed({in_point_y[COORD_W-1], in_point_y});
      last_r <= in_last_point;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_SQ0: begin
        mul_a = $signed({side_a_x_r[COORD_W-1], side_a_x_r});
        mul_b = side_a_x_r;
      end
      DP_SQ1: begin
        mul_a = $signed({side_a_y_r[COORD_W-1], side_a_y_r});
        mul_b = side_a_y_r;
      end
      DP_SQ2: begin
        mul_a = $signed({side_b_x_r[COORD_W-1], side_b_x_r});
        mul_b = side_b_x_r;
      end
      DP_SQ3: begin
        mul_a = $signed({side_b_y_r[COORD_W-1], side_b_y_r});
        mul_b = side_b_y_r;
      end
      DP_M0: begin
        mul_a = dx_r;
        mul_b = side_a_x_r;
      end
      DP_M1: begin
        mul_a = dy_r;
        mul_b = side_a_y_r;
      end
      DP_M2: begin
        mul_a = dx_r;
        mul_b = side_b_x_r;
      end
      DP_M3: begin
        mul_a = dy_r;
        mul_b = side_b_y_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_ext   = $signed({prod_r[PROD_W-1], prod_r});
  assign near_b_sum = near_b_r + prod_ext;

  // squared side lengths: the far test dot(d-s,s) <= 0 is dot(d,s) <= |s|^2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_a_r <= '0;
      sq_b_r <= '0;
    end else begin
      case (cmd.op)
        DP_SQ1:  sq_a_r <= prod_ext;
        DP_SQ2:  sq_a_r <= sq_a_r + prod_ext;
        DP_SQ3:  sq_b_r <= prod_ext;
        DP_SQ4:  sq_b_r <= sq_b_r + prod_ext;
        default: ;
      endcase
    end
  end

  // dot products and the side tests
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_M1: near_a_r <= prod_ext;
      DP_M2: near_a_r <= near_a_r + prod_ext;
      DP_M3: begin
        near_b_r <= prod_ext;
        in_a_r   <= (near_a_r > 0) && (near_a_r <= sq_a_r);
      end
      DP_TEST: inside_r <= in_a_r && (near_b_sum > 0) && (near_b_sum <= sq_b_r);
      default: ;
    endcase
  end

  // saturating weight add
  always_comb begin
    weight_sum = $signed({weight_acc_r[WEIGHT_W-1], weight_acc_r})
               + $signed({{(WEIGHT_W + 1 - DIFF_W){w_r[DIFF_W-1]}}, w_r});
    if (weight_sum[WEIGHT_W] != weight_sum[WEIGHT_W-1]) begin
      weight_sat = weight_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                        : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      weight_sat = weight_sum[WEIGHT_W-1:0];
    end
  end

  // running sums, cleared once a set is handed to the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_acc_r  <= '0;
      weight_acc_r <= '0;
    end else if (cmd.op == DP_UPDATE && inside_r) begin
      if (count_acc_r != '1) begin
        count_acc_r <= count_acc_r + 1'b1;
      end
      weight_acc_r <= weight_sat;
    end else if (cmd.op == DP_PREP) begin
      count_acc_r  <= '0;
      weight_acc_r <= '0;
    end
  end

  // divider step: restoring, one quotient bit into the dividend register
  assign weight_mag = weight_acc_r[WEIGHT_W-1] ? WEIGHT_W'(-weight_acc_r)
                                               : WEIGHT_W'(weight_acc_r);
  assign rem_sh   = {rem_r[COUNT_BITS-1:0], dvd_r[WEIGHT_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, cnt_hold_r};

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_PREP: begin
        cnt_hold_r <= count_acc_r;
        wt_hold_r  <= weight_acc_r;
        neg_r      <= weight_acc_r[WEIGHT_W-1];
        dvd_r      <= weight_mag;
        rem_r      <= '0;
      end
      DP_DIV: begin
        if (!rem_diff[COUNT_BITS+1]) begin
          rem_r <= rem_diff[COUNT_BITS:0];
          dvd_r <= {dvd_r[WEIGHT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          dvd_r <= {dvd_r[WEIGHT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // signed, clamped average from the quotient magnitude
  always_comb begin
    if (cnt_hold_r == '0) begin
      avg_val = '0;
    end else if (neg_r) begin
      avg_val = (dvd_r > AVG_NEG_MAG) ? AVG_W'(-AVG_NEG_MAG)
                                      : AVG_W'(-dvd_r);
    end else begin
      avg_val = (dvd_r > AVG_POS_MAX) ? AVG_POS_MAX[AVG_W-1:0]
                                      : dvd_r[AVG_W-1:0];
    end
  end

  assign count_wide = {{OUT_COUNT_W{1'b0}}, cnt_hold_r};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      out_count_r <= count_wide[OUT_COUNT_W-1:0];
      out_total_r <= wt_hold_r;
      out_avg_r   <= avg_val;
      out_empty_r <= (cnt_hold_r == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_inside_count   = out_count_r;
  assign out_weight_total   = out_total_r;
  assign out_weight_average = out_avg_r;
  assign out_set_empty      = out_empty_r;

  assign status.last      = last_r;
  assign status.acc_empty = (count_acc_r == '0);
  assign status.out_busy  = out_valid_r && out_stall;

endmodule

// ===== hdl/oriented_box_range_average_top.sv =====
`timescale 1ns / 1ps

// Oriented box range average.
// Input channel (in_valid / in_stall): one word per 2-D point, signed Q8.8,
// with in_last_point marking the end of a set. Points past the near edges and
// not past the far edges of the box (corner plus two side vectors, from the
// cfg_ write port) add to a count and to a weight sum of x + y.
// Output channel (out_valid / out_stall): one word per set, after its last
// point: count, weight total, average truncated toward zero, empty flag.
// Points are taken one at a time: the single multiplier forms the four products
// of the two dot products in turn, then the test and update steps run. After
// any register write, the squared side lengths are recomputed (SQ0 to SQ4)
// before the next point is taken.
// After a set's last point, its sums go to the bit-serial divider and the
// result is then registered for output; an empty set skips the divider.
// A finished result sits in the output register; points of the next set keep
// flowing while it is stalled, and only the next set's result waits for it.
// Reset (synchronous, rst_n low) clears the box registers and the sums to 0.
module oriented_box_range_average_top #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [obra_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [obra_pkg::COORD_W-1:0]  in_point_y,
  input  logic                                 in_last_point,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [obra_pkg::OUT_COUNT_W-1:0]     out_inside_count,
  output logic signed [obra_pkg::WEIGHT_W-1:0] out_weight_total,
  output logic signed [obra_pkg::AVG_W-1:0]    out_weight_average,
  output logic                                 out_set_empty,
  input  logic                                 cfg_we,
  input  logic [obra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [obra_pkg::COORD_W-1:0]         cfg_wdata
);
  import obra_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  obra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_we   (cfg_we),
    .cmd      (cmd),
    .status   (status)
  );

  // arithmetic and result register
  obra_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_last_point      (in_last_point),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_inside_count   (out_inside_count),
    .out_weight_total   (out_weight_total),
    .out_weight_average (out_weight_average),
    .out_set_empty      (out_set_empty)
  );

endmodule

// ===== hdl/obra_checker.sv =====
`timescale 1ns / 1ps

module obra_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [obra_pkg::OUT_COUNT_W-1:0]     out_inside_count,
  input logic signed [obra_pkg::WEIGHT_W-1:0] out_weight_total,
  input logic signed [obra_pkg::AVG_W-1:0]    out_weight_average,
  input logic                                 out_set_empty
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_count)
      && $stable(out_weight_total) && $stable(out_weight_average)
      && $stable(out_set_empty))
    else $error("result word changed while stalled");

  // one point at a time: a taken word closes the input for the next cycle
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // an empty set reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_set_empty |-> out_inside_count == 0
      && out_weight_total == 0 && out_weight_average == 0)
    else $error("empty set with non-zero result");

  // average keeps the sign of the total
  a_pos_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_weight_total[obra_pkg::WEIGHT_W-1]
      |-> !out_weight_average[obra_pkg::AVG_W-1])
    else $error("negative average for non-negative total");

  a_neg_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_weight_total[obra_pkg::WEIGHT_W-1]
      |-> out_weight_average[obra_pkg::AVG_W-1] || out_weight_average == 0)
    else $error("positive average for negative total");

endmodule

bind oriented_box_range_average_top obra_checker u_obra_checker (.*);

// ===== bench/tb_oriented_box_range_average_top.sv =====
`timescale 1ns / 1ps

module tb_oriented_box_range_average_top;
  import obra_pkg::*;

  localparam int unsigned COUNT_BITS = 20;
  localparam longint COUNT_CAP = (longint'(1) << COUNT_BITS) - 1;
  localparam longint WEIGHT_HI = (longint'(1) << (WEIGHT_W - 1)) - 1;
  localparam longint WEIGHT_LO = -WEIGHT_HI - 1;
  localparam longint AVG_HI = 65535;
  localparam longint AVG_LO = -65536;
  // divider latency plus margin
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1100;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic [WEIGHT_W-1:0]    total;
    logic [AVG_W-1:0]       avg;
    logic                   empty;
  } set_result_t;

  // corner first, so field k from the top sits at COORD_W * (5 - k)
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } box_t;

  typedef struct packed {
    logic [2:0]         box;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               typed;
    set_result_t        want;
  } point_row_t;

  localparam set_result_t NO_SET = '0;
  localparam set_result_t EMPTY_SET = '{20'd0, 38'd0, 17'd0, 1'b1};

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{
    REG_CORNER_X, REG_CORNER_Y, REG_SIDE_A_X, REG_SIDE_A_Y, REG_SIDE_B_X, REG_SIDE_B_Y
  };

  // directed boxes: reset (degenerate), axis aligned, extremes, centred, rotated
  localparam box_t DIRECTED_BOXES [5] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0400},
    '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF},
    '{16'hF800, 16'hF800, 16'h1000, 16'h0000, 16'h0000, 16'h1000},
    '{16'h0000, 16'h0000, 16'h0200, 16'h0200, 16'hFE00, 16'h0200}
  };

  localparam point_row_t DIRECTED [N_DIRECTED] = '{
    // reset box has zero sides, so every set comes back empty
    '{3'd0, 16'h8000, 16'h8000, 1'b0, 1'b0, NO_SET},
    '{3'd0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, EMPTY_SET},
    '{3'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, EMPTY_SET},
    // inside, far corner, near corner, near edge, outside, last inside
    '{3'd1, 16'h0100, 16'h0100, 1'b0, 1'b0, NO_SET},
    '{3'd1, 16'h0400, 16'h0400, 1'b0, 1'b0, NO_SET},
    '{3'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, NO_SET},
    '{3'd1, 16'h0400, 16'h0000, 1'b0, 1'b0, NO_SET},
    '{3'd1, 16'h07D0, 16'h0064, 1'b0, 1'b0, NO_SET},
    '{3'd1, 16'h0200, 16'h0300, 1'b1, 1'b0, NO_SET},
    // single outside point, empty set
    '{3'd1, 16'hFF00, 16'hFF00, 1'b1, 1'b0, NO_SET},
    // extreme box and extreme points
    '{3'd2, 16'h8064, 16'h80C8, 1'b0, 1'b0, NO_SET},
    '{3'd2, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, NO_SET},
    '{3'd2, 16'h8000, 16'h8000, 1'b1, 1'b0, NO_SET},
    // truncation toward zero, negative then positive
    '{3'd3, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_SET},
    '{3'd3, 16'hFFFF, 16'h0000, 1'b1, 1'b0, NO_SET},
    '{3'd3, 16'h0001, 16'h0000, 1'b0, 1'b0, NO_SET},
    '{3'd3, 16'h0001, 16'h0001, 1'b1, 1'b0, NO_SET},
    // rotated box: inside, outside, far corner
    '{3'd4, 16'h0000, 16'h0100, 1'b0, 1'b0, NO_SET},
    '{3'd4, 16'h0100, 16'h0000, 1'b0, 1'b0, NO_SET},
    '{3'd4, 16'h0000, 16'h0400, 1'b1, 1'b0, NO_SET}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [COORD_W-1:0]   in_point_x = '0;
  logic signed [COORD_W-1:0]   in_point_y = '0;
  logic                        in_last_point = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [OUT_COUNT_W-1:0]      out_inside_count;
  logic signed [WEIGHT_W-1:0]  out_weight_total;
  logic signed [AVG_W-1:0]     out_weight_average;
  logic                        out_set_empty;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [COORD_W-1:0]          cfg_wdata = '0;

  // box as the block should hold it, and the running sums of the open set
  longint box_cx = 0, box_cy = 0, box_ax = 0, box_ay = 0, box_bx = 0, box_by = 0;
  longint run_count = 0;
  longint run_weight = 0;
  set_result_t pending_sets [$];

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int mismatches = 0;
  int sets_seen = 0;
  int empty_seen = 0;
  int items_sent = 0;
  int box_writes = 0;

  oriented_box_range_average_top #(.COUNT_BITS(COUNT_BITS)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_last_point      (in_last_point),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_inside_count   (out_inside_count),
    .out_weight_total   (out_weight_total),
    .out_weight_average (out_weight_average),
    .out_set_empty      (out_set_empty),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // one side of the box: strictly past the near edge, not past the far one
  function automatic bit side_holds(longint dx, longint dy, longint sx, longint sy);
    longint dot_near;
    longint dot_far;
    dot_near = dx * sx + dy * sy;
    dot_far = (dx - sx) * sx + (dy - sy) * sy;
    return (dot_near > 0) && (dot_far <= 0);
  endfunction

  // fold one accepted point into the sums; a last point closes the set
  task automatic account_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic last, input logic typed,
                               input set_result_t want);
    longint px;
    longint py;
    longint dx;
    longint dy;
    longint quot;
    set_result_t res;
    px = longint'($signed(x));
    py = longint'($signed(y));
    dx = px - box_cx;
    dy = py - box_cy;
    if (side_holds(dx, dy, box_ax, box_ay) && side_holds(dx, dy, box_bx, box_by)) begin
      if (run_count < COUNT_CAP) run_count++;
      run_weight += px + py;
      if (run_weight > WEIGHT_HI) run_weight = WEIGHT_HI;
      if (run_weight < WEIGHT_LO) run_weight = WEIGHT_LO;
    end
    if (last) begin
      quot = 0;
      if (run_count != 0) begin
        quot = run_weight / run_count;
        if (quot > AVG_HI) quot = AVG_HI;
        if (quot < AVG_LO) quot = AVG_LO;
      end
      res.count = run_count[OUT_COUNT_W-1:0];
      res.total = run_weight[WEIGHT_W-1:0];
      res.avg = quot[AVG_W-1:0];
      res.empty = (run_count == 0);
      pending_sets.push_back(typed ? want : res);
      run_count = 0;
      run_weight = 0;
    end
  endtask

  // offer one word, with a random gap first, and hold it until taken
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last, input logic typed,
                            input set_result_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    account_point(x, y, last, typed, want);
  endtask

  // all results in, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_box(input box_t b);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= b[COORD_W * (5 - i) +: COORD_W];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    box_cx = longint'($signed(b.cx));
    box_cy = longint'($signed(b.cy));
    box_ax = longint'($signed(b.ax));
    box_ay = longint'($signed(b.ay));
    box_bx = longint'($signed(b.bx));
    box_by = longint'($signed(b.by));
    box_writes++;
  endtask

  // mostly sensible near-rectangles, some raw, extreme or degenerate boxes
  function automatic box_t random_box();
    box_t b;
    int unsigned pick;
    longint cx;
    longint cy;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint m;
    pick = $urandom_range(9);
    if (pick == 0) begin
      b = {$urandom, $urandom, $urandom};
    end else if (pick == 1) begin
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(3))
          0: b[COORD_W * k +: COORD_W] = 16'h8000;
          1: b[COORD_W * k +: COORD_W] = 16'h7FFF;
          2: b[COORD_W * k +: COORD_W] = 16'h0000;
          default: b[COORD_W * k +: COORD_W] = 16'hFFFF;
        endcase
      end
    end else begin
      cx = longint'($urandom_range(16383)) - 8192;
      cy = longint'($urandom_range(16383)) - 8192;
      ax = longint'($urandom_range(8191)) - 4096;
      ay = longint'($urandom_range(8191)) - 4096;
      m = longint'($urandom_range(1, 6));
      bx = -(ay * m) / 4 + longint'($urandom_range(128)) - 64;
      by = (ax * m) / 4 + longint'($urandom_range(128)) - 64;
      // a zero side now and then
      if (pick == 2) begin
        if ($urandom_range(1) == 0) begin
          ax = 0;
          ay = 0;
        end else begin
          bx = 0;
          by = 0;
        end
      end
      b = {cx[15:0], cy[15:0], ax[15:0], ay[15:0], bx[15:0], by[15:0]};
    end
    return b;
  endfunction

  // mostly points spread over the box and just beyond its edges, rest noise
  task automatic random_point(input logic last);
    longint u;
    longint v;
    longint px;
    longint py;
    if ($urandom_range(99) < 70) begin
      u = longint'($urandom_range(296)) - 20;
      v = longint'($urandom_range(296)) - 20;
      px = box_cx + (box_ax * u + box_bx * v) / 256;
      py = box_cy + (box_ay * u + box_by * v) / 256;
      send_point(px[15:0], py[15:0], last, 1'b0, NO_SET);
    end else begin
      send_point(16'($urandom_range(65535)), 16'($urandom_range(65535)), last, 1'b0, NO_SET);
    end
  endtask

  // result side: random stall, and compare each taken word with the oldest set
  always @(posedge clk) begin
    set_result_t want;
    out_stall <= (out_idle_pct != 0) && ($urandom_range(99) < out_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sets.size() == 0) begin
        report($sformatf("unexpected result count %0d total %0d avg %0d empty %0b",
                         out_inside_count, out_weight_total, out_weight_average,
                         out_set_empty));
      end else begin
        want = pending_sets.pop_front();
        sets_seen++;
        if (want.empty) empty_seen++;
        if (out_inside_count !== want.count)
          report($sformatf("inside_count %0d, want %0d", out_inside_count, want.count));
        if (out_weight_total !== $signed(want.total))
          report($sformatf("weight_total %0d, want %0d", out_weight_total,
                           $signed(want.total)));
        if (out_weight_average !== $signed(want.avg))
          report($sformatf("weight_average %0d, want %0d", out_weight_average,
                           $signed(want.avg)));
        if (out_set_empty !== want.empty)
          report($sformatf("set_empty %0b, want %0b", out_set_empty, want.empty));
      end
    end
  end

  // stimulus
  initial begin
    int cur_box;
    int budget;
    int phase_end;
    int set_len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reconfiguring whenever the box changes
    cur_box = 0;
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (int'(DIRECTED[r].box) != cur_box) begin
        settle();
        cur_box = int'(DIRECTED[r].box);
        write_box(DIRECTED_BOXES[cur_box]);
      end
      send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].last, DIRECTED[r].typed,
                 DIRECTED[r].want);
    end

    // random sets under three idling mixes, fresh box every few dozen words
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          in_idle_pct = 25;
          out_idle_pct = 65;
        end
        1: begin
          in_idle_pct = 65;
          out_idle_pct = 25;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      budget = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < budget) begin
        settle();
        write_box(random_box());
        phase_end = items_sent + $urandom_range(30, 80);
        while (items_sent < phase_end) begin
          set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          for (int k = 1; k <= set_len; k++) random_point(k == set_len);
        end
      end
    end

    settle();
    $display("covered %0d points in %0d sets (%0d empty) over %0d box settings",
             items_sent, sets_seen, empty_seen, box_writes);
    $display("idle mixes: sender/receiver 25/65, 65/25, then back to back");
    if (mismatches == 0) begin
      $display("oriented_box_range_average_top verification clean");
    end else begin
      $display("oriented_box_range_average_top verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #1_000_000;
    $display("oriented_box_range_average_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/obra_pkg.sv
hdl/obra_ctrl.sv
hdl/obra_dp.sv
hdl/oriented_box_range_average_top.sv
hdl/obra_checker.sv
bench/tb_oriented_box_range_average_top.sv
